>>> hdl/rsd_pkg.sv
// shared types and constants for the rice stream decoder
`timescale 1ns / 1ps

package rsd_pkg;

  // bits per input byte and the widths that follow from it
  localparam int unsigned ByteW = 8;
  localparam int unsigned SymW  = 8;
  localparam int unsigned CntW  = 4;   // holds 0 .. ByteW results
  localparam int unsigned IdxW  = 3;   // indexes ByteW result slots

  // header length in bits, holding k msb first
  localparam logic [1:0] HdrDone = 2'd3;

  // decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0] hdr_seen;
    logic [2:0] rice_k;
    logic       rem_phase;
    logic [7:0] qcnt;
    logic [6:0] racc;
    logic [2:0] rleft;
  } rsd_state_t;

  // all results caused by one byte
  typedef struct packed {
    logic [ByteW-1:0][SymW-1:0] syms;
    logic [CntW-1:0]            cnt;
    logic                       bare;   // single end marker, no symbol
    logic                       last;   // byte closed the stream
  } rsd_result_t;

endpackage

>>> hdl/rsd_decode.sv
// single-pass decode of one byte: eight bit steps against the carried state
`timescale 1ns / 1ps

module rsd_decode (
  input  logic [rsd_pkg::ByteW-1:0] byte_i,
  input  logic                      last_i,
  input  rsd_pkg::rsd_state_t       state_i,
  output rsd_pkg::rsd_state_t       state_o,
  output rsd_pkg::rsd_result_t      result_o
);
  import rsd_pkg::*;

  // drop the code in progress, keep header and k
  function automatic rsd_state_t clear_code(input rsd_state_t s);
    rsd_state_t r;
    r           = s;
    r.rem_phase = 1'b0;
    r.qcnt      = '0;
    r.racc      = '0;
    r.rleft     = '0;
    return r;
  endfunction

  rsd_state_t      st;
  rsd_result_t     res;
  logic [CntW-1:0] n;
  logic            b;
  logic            done;
  logic [SymW-1:0] sym;

  // walk the byte lsb first, collecting finished symbols in order
  always_comb begin
    st   = state_i;
    res  = '0;
    n    = '0;
    b    = 1'b0;
    done = 1'b0;
    sym  = '0;
    for (int i = 0; i < ByteW; i++) begin
      b    = byte_i[i];
      done = 1'b0;
      sym  = '0;
      if (st.hdr_seen != HdrDone) begin
        st.rice_k   = {st.rice_k[1:0], b};
        st.hdr_seen = st.hdr_seen + 2'd1;
      end else if (!st.rem_phase) begin
        if (b) begin
          st.qcnt = st.qcnt + 8'd1;
        end else if (st.rice_k == '0) begin
          sym  = st.qcnt;
          done = 1'b1;
          st   = clear_code(st);
        end else begin
          st.rem_phase = 1'b1;
          st.racc      = '0;
          st.rleft     = st.rice_k;
        end
      end else begin
        st.racc  = {st.racc[5:0], b};
        st.rleft = st.rleft - 3'd1;
        if (st.rleft == '0) begin
          sym  = (st.qcnt << st.rice_k) | {1'b0, st.racc};
          done = 1'b1;
          st   = clear_code(st);
        end
      end
      if (done) begin
        res.syms[n[IdxW-1:0]] = sym;
        n = n + 1'b1;
      end
    end
    // end of stream: bare marker if nothing finished, then back to reset state
    if (last_i) begin
      if (n == '0) begin
        res.bare = 1'b1;
        n        = CntW'(1);
      end
      st = '0;
    end
    res.cnt  = n;
    res.last = last_i;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

>>> hdl/rsd_result_buf.sv
// result register for one byte, drained one item per cycle while out_ready_i is high
`timescale 1ns / 1ps

module rsd_result_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  rsd_pkg::rsd_result_t  result_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [rsd_pkg::SymW-1:0] symbol_o,
  output logic                  symbol_valid_o,
  output logic                  run_last_o,
  output logic                  stream_end_o
);
  import rsd_pkg::*;

  logic [ByteW-1:0][SymW-1:0] syms_q;
  logic [CntW-1:0]            cnt_q;
  logic [IdxW-1:0]            idx_q;
  logic                       bare_q;
  logic                       last_q;
  logic                       valid_q;
  logic                       is_final;
  logic                       take;

  // current slot is the last one of this byte
  assign is_final = ({1'b0, idx_q} == (cnt_q - 1'b1));
  assign take     = valid_q && out_ready_i;
  assign free_o   = !valid_q || (take && is_final);

  // control: slot index and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= (result_i.cnt != '0);
      idx_q   <= '0;
    end else if (take) begin
      if (is_final) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // payload held while the item drains
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      syms_q <= result_i.syms;
      cnt_q  <= result_i.cnt;
      bare_q <= result_i.bare;
      last_q <= result_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign symbol_o       = syms_q[idx_q];
  assign symbol_valid_o = !bare_q;
  assign run_last_o     = is_final;
  assign stream_end_o   = last_q && is_final;

endmodule

>>> hdl/rice_stream_decoder.sv
// top level of the rice stream decoder: input register, decoder, result buffer
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------------
//   in      | in_valid_i / in_ready_o | in_byte_i, in_last_i
//   out     | out_valid_o/out_ready_i | symbol_o, symbol_valid_o, run_last_o, stream_end_o
//
// a byte waits in the input register, then decodes in one pass into the result buffer;
// a last byte that completes no symbol gives one bare end marker, any other such byte
// gives none. while out_ready_i is high, a byte leaves as one output item per decoded
// symbol, one per cycle, and a byte with zero or one results sustains one byte per cycle;
// a byte with more results holds the input while they drain through the result buffer's
// single output port. reset clears the decoder state (new header expected) and both valid
// flags. a stalled output holds the buffer, and the input register fills and then stalls.
`timescale 1ns / 1ps

module rice_stream_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rsd_pkg::ByteW-1:0]  in_byte_i,
  input  logic                       in_last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rsd_pkg::SymW-1:0]   symbol_o,
  output logic                       symbol_valid_o,
  output logic                       run_last_o,
  output logic                       stream_end_o
);
  import rsd_pkg::*;

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  rsd_state_t       state_q;
  rsd_state_t       state_d;
  rsd_result_t      result;
  logic             buf_free;
  logic             advance;

  // the input item moves on when the result buffer can take its results
  assign advance    = in_vld_q && buf_free;
  assign in_ready_o = !in_vld_q || advance;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  // decoder state, updated once per decoded byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  rsd_decode u_decode (
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  rsd_result_buf u_result_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance),
    .result_i       (result),
    .free_o         (buf_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .symbol_valid_o (symbol_valid_o),
    .run_last_o     (run_last_o),
    .stream_end_o   (stream_end_o)
  );

endmodule
